// File: hdl/chgs_pkg.sv
// Shared constants, types and a helper function of the convex hull block.
`default_nettype none

package chgs_pkg;

    // Store depth and coordinate format.
    localparam int MAX_POINTS = 64;
    localparam int COORD_W    = 24;

    // Derived widths.
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int PT_W       = 2 * COORD_W;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int SUM_W      = COORD_W + 2;
    localparam int GUARD_INIT = 4 * MAX_POINTS + 4;
    localparam int GUARD_W    = $clog2(GUARD_INIT + 1);
    localparam int MIN_HULL   = 3;
    localparam int PIVOT_TAPS = 3;

    // One stored point, x in the low half.
    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    // Operation of the compare unit.
    typedef enum logic {
        CMP_CROSS = 1'b0,
        CMP_DIST  = 1'b1
    } cmp_mode_t;

    typedef struct packed {
        logic      start;
        cmp_mode_t mode;
    } cmp_req_t;

    typedef struct packed {
        logic done;
        logic gt;
        logic lt;
    } cmp_res_t;

    // Full-width difference of two coordinates.
    function automatic logic signed [DIFF_W-1:0] coord_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

endpackage

`default_nettype wire

// File: hdl/chgs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module chgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/chgs_cmp.sv
// Multi-cycle compare unit: sign of a cross product or order of two squared lengths.
`default_nettype none

module chgs_cmp
    import chgs_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cmp_req_t                 req,
    input  wire logic signed [DIFF_W-1:0] ax,
    input  wire logic signed [DIFF_W-1:0] ay,
    input  wire logic signed [DIFF_W-1:0] bx,
    input  wire logic signed [DIFF_W-1:0] by,
    output cmp_res_t                      res
);

    localparam logic [2:0] LAST_MUL  = 3'd3;
    localparam logic [2:0] LAST_ACC  = 3'd4;
    localparam logic [2:0] DONE_STEP = 3'd5;
    localparam logic [2:0] LHS_LAST  = 3'd2;

    logic                     busy_reg;
    logic [2:0]               step_reg;
    cmp_mode_t                mode_reg;
    logic signed [DIFF_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  lhs_reg, rhs_reg;
    logic signed [DIFF_W-1:0] mul_a, mul_b;

    // Operand selection: cross uses ax*by vs ay*bx, distance sums the squares.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg[1:0])
            2'd0:
            begin
                mul_a = ax_reg;
                mul_b = (mode_reg == CMP_CROSS) ? by_reg : ax_reg;
            end
            2'd1:
            begin
                mul_a = ay_reg;
                mul_b = (mode_reg == CMP_CROSS) ? '0 : ay_reg;
            end
            2'd2:
            begin
                mul_a = (mode_reg == CMP_CROSS) ? ay_reg : bx_reg;
                mul_b = bx_reg;
            end
            default:
            begin
                mul_a = by_reg;
                mul_b = (mode_reg == CMP_CROSS) ? '0 : by_reg;
            end
        endcase
    end

    // Control of the step sequence.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == DONE_STEP)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    // Multiply into the product register, then accumulate that product in the next cycle.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mode_reg <= req.mode;
            ax_reg   <= ax;
            ay_reg   <= ay;
            bx_reg   <= bx;
            by_reg   <= by;
            lhs_reg  <= '0;
            rhs_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg <= LAST_MUL)
            begin
                prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
            end
            if (step_reg != '0 && step_reg <= LAST_ACC)
            begin
                if (step_reg <= LHS_LAST)
                begin
                    lhs_reg <= lhs_reg + ACC_W'(prod_reg);
                end
                else
                begin
                    rhs_reg <= rhs_reg + ACC_W'(prod_reg);
                end
            end
        end
    end

    assign res.done = busy_reg && (step_reg == DONE_STEP);
    assign res.gt   = lhs_reg > rhs_reg;
    assign res.lt   = lhs_reg < rhs_reg;

endmodule

`default_nettype wire

// File: hdl/convex_hull_graham_scan.sv
// Top level of the convex hull block: load, pivot, sort, Graham scan and hull output.
//
// Channel   Dir  tdata (low bit up)               tlast        tuser
// s_axis    in   coord_x[23:0], coord_y[47:24]    last_point   -
// m_axis    out  hull_x[23:0], hull_y[47:24]      hull_last    degenerate
//
// After a point's transaction the duplicate search reads one stored point per cycle and a hit
// ends it; a new point is then stored if there is room, before s_axis_tready rises again.
// After the last point the block computes the pivot, sorts the points by insertion, searches
// for the start point and runs the scan steps, some of which remove a vertex. Each hull
// vertex is held until m_axis_tready.
// Reset is asynchronous; the RAMs need no clearing.
// s_axis_tready is high only while the block waits for the next point.
`default_nettype none

module convex_hull_graham_scan
    import chgs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // coord_x[23:0], coord_y[47:24]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // hull_x[23:0], hull_y[47:24]
    output logic             m_axis_tlast,
    output logic [0:0]       m_axis_tuser   // degenerate[0]
);

    localparam int ST_N = 28;

    typedef enum logic [ST_N-1:0] {
        ST_IDLE    = ST_N'(1) << 0,
        ST_DUP     = ST_N'(1) << 1,
        ST_STORE   = ST_N'(1) << 2,
        ST_FIN     = ST_N'(1) << 3,
        ST_DIV     = ST_N'(1) << 4,
        ST_SRT_I   = ST_N'(1) << 5,
        ST_SRT_T   = ST_N'(1) << 6,
        ST_SRT_RD  = ST_N'(1) << 7,
        ST_SRT_U   = ST_N'(1) << 8,
        ST_ORD     = ST_N'(1) << 9,
        ST_ORD_X   = ST_N'(1) << 10,
        ST_ORD_D   = ST_N'(1) << 11,
        ST_SRT_MV  = ST_N'(1) << 12,
        ST_FS_RD   = ST_N'(1) << 13,
        ST_FS_CMP  = ST_N'(1) << 14,
        ST_SC_TOP  = ST_N'(1) << 15,
        ST_SC_NX   = ST_N'(1) << 16,
        ST_SC_NN   = ST_N'(1) << 17,
        ST_SC_PV   = ST_N'(1) << 18,
        ST_SC_PX   = ST_N'(1) << 19,
        ST_SC_PN   = ST_N'(1) << 20,
        ST_SC_WAIT = ST_N'(1) << 21,
        ST_SC_BACK = ST_N'(1) << 22,
        ST_SC_PREV = ST_N'(1) << 23,
        ST_EM_RD   = ST_N'(1) << 24,
        ST_EM_NX   = ST_N'(1) << 25,
        ST_EM_PT   = ST_N'(1) << 26,
        ST_EM_OUT  = ST_N'(1) << 27
    } state_t;

    // Direction classes around the pivot, in sort order.
    localparam logic [2:0] CLS_POSX = 3'd0;
    localparam logic [2:0] CLS_PIV  = 3'd1;
    localparam logic [2:0] CLS_UP   = 3'd2;
    localparam logic [2:0] CLS_NEGX = 3'd3;
    localparam logic [2:0] CLS_LOW  = 3'd4;

    // Reciprocal of three, exact for every dividend below 2**32.
    localparam int                REC_SH = 33;
    localparam int                REC_W  = SUM_W + REC_SH;
    localparam logic [REC_SH-1:0] RECIP3 = 33'h0AAAAAAAB;

    function automatic logic [2:0] dir_class(
        input logic signed [DIFF_W-1:0] dx,
        input logic signed [DIFF_W-1:0] dy
    );
        logic [2:0] c;
        if (dy > 0)
            c = CLS_UP;
        else if (dy < 0)
            c = CLS_LOW;
        else if (dx > 0)
            c = CLS_POSX;
        else if (dx < 0)
            c = CLS_NEGX;
        else
            c = CLS_PIV;
        return c;
    endfunction

    state_t state_reg, state_next;

    // Run state.
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [1:0]              seen_reg, seen_next;
    logic signed [SUM_W-1:0] sumx_reg, sumx_next, sumy_reg, sumy_next;
    point_t                  new_reg, new_next;
    logic                    last_reg, last_next;
    logic [CNT_W-1:0]        dup_idx_reg, dup_idx_next;
    logic                    pend_reg, pend_next;

    // Pivot division.
    logic [SUM_W-1:0]        magx_reg, magx_next, magy_reg, magy_next;
    logic                    negx_reg, negx_next, negy_reg, negy_next;
    point_t                  pivot_reg, pivot_next;
    logic [REC_W-1:0]        recx, recy;
    logic [SUM_W-1:0]        quox, quoy;

    // Sort.
    logic [CNT_W-1:0]        i_reg, i_next, j_reg, j_next;
    point_t                  t_reg, t_next, u_reg, u_next;
    logic                    before_reg, before_next;

    // Start search and scan.
    logic [CNT_W-1:0]        fs_reg, fs_next;
    point_t                  best_reg, best_next;
    logic [IDX_W-1:0]        start_reg, start_next;
    logic [IDX_W-1:0]        v_reg, v_next, nx_reg, nx_next, nn_reg, nn_next;
    point_t                  pv_reg, pv_next, px_reg, px_next;
    logic [GUARD_W-1:0]      guard_reg, guard_next;

    // Output.
    logic [IDX_W-1:0]        nv_reg, nv_next;
    logic [CNT_W-1:0]        em_reg, em_next;
    logic                    oval_reg, oval_next;
    point_t                  opt_reg, opt_next;
    logic                    olast_reg, olast_next;
    logic                    odeg_reg, odeg_next;

    // RAM ports.
    logic             pt_we, nxt_we, prv_we;
    logic [IDX_W-1:0] pt_waddr, pt_raddr, lnk_waddr, nxt_raddr, prv_raddr;
    point_t           pt_wdata, pt_rdata;
    logic [IDX_W-1:0] nxt_wdata, prv_wdata, nxt_rdata, prv_rdata;

    // Compare unit.
    cmp_req_t                 cmp_req;
    cmp_res_t                 cmp_res;
    logic signed [DIFF_W-1:0] cax, cay, cbx, cby;

    // Helpers.
    point_t                   in_pt;
    logic signed [DIFF_W-1:0] dtx, dty, dux, duy;
    logic [2:0]               cls_t, cls_u;
    logic [CNT_W-1:0]         j_dec, fs_inc, em_inc, cnt_dec;
    logic                     fs_better;

    assign in_pt = point_t'(s_axis_tdata);
    assign dtx   = coord_diff(t_reg.x, pivot_reg.x);
    assign dty   = coord_diff(t_reg.y, pivot_reg.y);
    assign dux   = coord_diff(u_reg.x, pivot_reg.x);
    assign duy   = coord_diff(u_reg.y, pivot_reg.y);
    assign cls_t = dir_class(dtx, dty);
    assign cls_u = dir_class(dux, duy);
    assign j_dec   = j_reg - CNT_W'(1);
    assign fs_inc  = fs_reg + CNT_W'(1);
    assign em_inc  = em_reg + CNT_W'(1);
    assign cnt_dec = cnt_reg - CNT_W'(1);
    assign recx = REC_W'(magx_reg) * REC_W'(RECIP3);
    assign recy = REC_W'(magy_reg) * REC_W'(RECIP3);
    assign quox = recx[REC_SH +: SUM_W];
    assign quoy = recy[REC_SH +: SUM_W];
    assign fs_better = (fs_reg == '0) || (pt_rdata.y < best_reg.y) ||
                       ((pt_rdata.y == best_reg.y) && (pt_rdata.x < best_reg.x));

    // Operands of the compare unit: pivot-relative in the sort, vertex-relative in the scan.
    always_comb
    begin
        if (state_reg == ST_SC_PN)
        begin
            cax = coord_diff(px_reg.x, pv_reg.x);
            cay = coord_diff(px_reg.y, pv_reg.y);
            cbx = coord_diff(pt_rdata.x, pv_reg.x);
            cby = coord_diff(pt_rdata.y, pv_reg.y);
        end
        else
        begin
            cax = dtx;
            cay = dty;
            cbx = dux;
            cby = duy;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        seen_next    = seen_reg;
        sumx_next    = sumx_reg;
        sumy_next    = sumy_reg;
        new_next     = new_reg;
        last_next    = last_reg;
        dup_idx_next = dup_idx_reg;
        pend_next    = pend_reg;
        magx_next    = magx_reg;
        magy_next    = magy_reg;
        negx_next    = negx_reg;
        negy_next    = negy_reg;
        pivot_next   = pivot_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        t_next       = t_reg;
        u_next       = u_reg;
        before_next  = before_reg;
        fs_next      = fs_reg;
        best_next    = best_reg;
        start_next   = start_reg;
        v_next       = v_reg;
        nx_next      = nx_reg;
        nn_next      = nn_reg;
        pv_next      = pv_reg;
        px_next      = px_reg;
        guard_next   = guard_reg;
        nv_next      = nv_reg;
        em_next      = em_reg;
        oval_next    = oval_reg;
        opt_next     = opt_reg;
        olast_next   = olast_reg;
        odeg_next    = odeg_reg;

        pt_we     = 1'b0;
        pt_waddr  = cnt_reg[IDX_W-1:0];
        pt_wdata  = new_reg;
        pt_raddr  = '0;
        nxt_we    = 1'b0;
        prv_we    = 1'b0;
        lnk_waddr = v_reg;
        nxt_wdata = nn_reg;
        prv_wdata = v_reg;
        nxt_raddr = v_reg;
        prv_raddr = v_reg;
        cmp_req.start = 1'b0;
        cmp_req.mode  = CMP_CROSS;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    new_next     = in_pt;
                    last_next    = s_axis_tlast;
                    dup_idx_next = '0;
                    pend_next    = 1'b0;
                    if (seen_reg < 2'(PIVOT_TAPS))
                    begin
                        sumx_next = sumx_reg + SUM_W'(in_pt.x);
                        sumy_next = sumy_reg + SUM_W'(in_pt.y);
                        seen_next = seen_reg + 2'd1;
                    end
                    state_next = ST_DUP;
                end
            end

            ST_DUP:
            begin
                // Reads issue every cycle; the data of the previous read is checked.
                pt_raddr = dup_idx_reg[IDX_W-1:0];
                if (pend_reg && pt_rdata == new_reg)
                begin
                    state_next = ST_FIN;
                end
                else if (dup_idx_reg < cnt_reg)
                begin
                    dup_idx_next = dup_idx_reg + CNT_W'(1);
                    pend_next    = 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            ST_STORE:
            begin
                if (cnt_reg < CNT_W'(MAX_POINTS))
                begin
                    pt_we    = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (cnt_reg < CNT_W'(MIN_HULL))
                begin
                    oval_next  = 1'b1;
                    opt_next   = '0;
                    olast_next = 1'b1;
                    odeg_next  = 1'b1;
                    state_next = ST_EM_OUT;
                end
                else
                begin
                    negx_next  = sumx_reg[SUM_W-1];
                    negy_next  = sumy_reg[SUM_W-1];
                    magx_next  = sumx_reg[SUM_W-1] ? SUM_W'(-sumx_reg) : SUM_W'(sumx_reg);
                    magy_next  = sumy_reg[SUM_W-1] ? SUM_W'(-sumy_reg) : SUM_W'(sumy_reg);
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                // Truncated division of the magnitudes by three, sign restored afterwards.
                pivot_next.x = negx_reg ? COORD_W'(-quox) : COORD_W'(quox);
                pivot_next.y = negy_reg ? COORD_W'(-quoy) : COORD_W'(quoy);
                i_next       = CNT_W'(1);
                state_next   = ST_SRT_I;
            end

            ST_SRT_I:
            begin
                pt_raddr = i_reg[IDX_W-1:0];
                if (i_reg >= cnt_reg)
                begin
                    fs_next    = '0;
                    state_next = ST_FS_RD;
                end
                else
                begin
                    state_next = ST_SRT_T;
                end
            end

            ST_SRT_T:
            begin
                t_next     = pt_rdata;
                j_next     = i_reg;
                state_next = ST_SRT_RD;
            end

            ST_SRT_RD:
            begin
                pt_raddr = j_dec[IDX_W-1:0];
                if (j_reg == '0)
                begin
                    pt_we      = 1'b1;
                    pt_waddr   = '0;
                    pt_wdata   = t_reg;
                    i_next     = i_reg + CNT_W'(1);
                    state_next = ST_SRT_I;
                end
                else
                begin
                    state_next = ST_SRT_U;
                end
            end

            ST_SRT_U:
            begin
                u_next     = pt_rdata;
                state_next = ST_ORD;
            end

            ST_ORD:
            begin
                // Angular class first, then cross product for the upper and lower classes, then distance.
                if (cls_t != cls_u)
                begin
                    before_next = cls_t < cls_u;
                    state_next  = ST_SRT_MV;
                end
                else if (cls_t == CLS_UP || cls_t == CLS_LOW)
                begin
                    cmp_req.start = 1'b1;
                    cmp_req.mode  = CMP_CROSS;
                    state_next    = ST_ORD_X;
                end
                else
                begin
                    cmp_req.start = 1'b1;
                    cmp_req.mode  = CMP_DIST;
                    state_next    = ST_ORD_D;
                end
            end

            ST_ORD_X:
            begin
                if (cmp_res.done)
                begin
                    if (cmp_res.gt || cmp_res.lt)
                    begin
                        before_next = cmp_res.gt;
                        state_next  = ST_SRT_MV;
                    end
                    else
                    begin
                        cmp_req.start = 1'b1;
                        cmp_req.mode  = CMP_DIST;
                        state_next    = ST_ORD_D;
                    end
                end
            end

            ST_ORD_D:
            begin
                if (cmp_res.done)
                begin
                    before_next = cmp_res.lt;
                    state_next  = ST_SRT_MV;
                end
            end

            ST_SRT_MV:
            begin
                pt_we    = 1'b1;
                pt_waddr = j_reg[IDX_W-1:0];
                if (before_reg)
                begin
                    pt_wdata   = u_reg;
                    j_next     = j_dec;
                    state_next = ST_SRT_RD;
                end
                else
                begin
                    pt_wdata   = t_reg;
                    i_next     = i_reg + CNT_W'(1);
                    state_next = ST_SRT_I;
                end
            end

            ST_FS_RD:
            begin
                pt_raddr   = fs_reg[IDX_W-1:0];
                state_next = ST_FS_CMP;
            end

            ST_FS_CMP:
            begin
                // Track the lowest-then-leftmost point and lay out the circular links.
                if (fs_better)
                begin
                    best_next  = pt_rdata;
                    start_next = fs_reg[IDX_W-1:0];
                end
                nxt_we    = 1'b1;
                prv_we    = 1'b1;
                lnk_waddr = fs_reg[IDX_W-1:0];
                nxt_wdata = (fs_inc == cnt_reg) ? '0 : fs_inc[IDX_W-1:0];
                prv_wdata = (fs_reg == '0) ? cnt_dec[IDX_W-1:0] : fs_reg[IDX_W-1:0] - IDX_W'(1);
                fs_next   = fs_inc;
                if (fs_inc == cnt_reg)
                begin
                    v_next     = fs_better ? fs_reg[IDX_W-1:0] : start_reg;
                    guard_next = GUARD_W'(GUARD_INIT);
                    state_next = ST_SC_TOP;
                end
                else
                begin
                    state_next = ST_FS_RD;
                end
            end

            ST_SC_TOP:
            begin
                nxt_raddr  = v_reg;
                state_next = ST_SC_NX;
            end

            ST_SC_NX:
            begin
                nx_next   = nxt_rdata;
                nxt_raddr = nxt_rdata;
                if (nxt_rdata == start_reg || guard_reg == '0)
                begin
                    v_next     = start_reg;
                    em_next    = '0;
                    state_next = ST_EM_RD;
                end
                else
                begin
                    guard_next = guard_reg - GUARD_W'(1);
                    state_next = ST_SC_NN;
                end
            end

            ST_SC_NN:
            begin
                nn_next    = nxt_rdata;
                pt_raddr   = v_reg;
                state_next = ST_SC_PV;
            end

            ST_SC_PV:
            begin
                pv_next    = pt_rdata;
                pt_raddr   = nx_reg;
                state_next = ST_SC_PX;
            end

            ST_SC_PX:
            begin
                px_next    = pt_rdata;
                pt_raddr   = nn_reg;
                state_next = ST_SC_PN;
            end

            ST_SC_PN:
            begin
                cmp_req.start = 1'b1;
                cmp_req.mode  = CMP_CROSS;
                state_next    = ST_SC_WAIT;
            end

            ST_SC_WAIT:
            begin
                if (cmp_res.done)
                begin
                    if (cmp_res.gt)
                    begin
                        v_next     = nx_reg;
                        state_next = ST_SC_TOP;
                    end
                    else
                    begin
                        // Unlink the middle vertex.
                        nxt_we     = 1'b1;
                        lnk_waddr  = v_reg;
                        nxt_wdata  = nn_reg;
                        state_next = ST_SC_BACK;
                    end
                end
            end

            ST_SC_BACK:
            begin
                prv_we    = 1'b1;
                lnk_waddr = nn_reg;
                prv_wdata = v_reg;
                state_next = (v_reg != start_reg) ? ST_SC_PREV : ST_SC_TOP;
            end

            ST_SC_PREV:
            begin
                // The previous link of v was read during the link update; step back to it.
                prv_raddr  = v_reg;
                state_next = ST_SC_TOP;
            end

            ST_EM_RD:
            begin
                nxt_raddr  = v_reg;
                state_next = ST_EM_NX;
            end

            ST_EM_NX:
            begin
                nv_next    = nxt_rdata;
                pt_raddr   = v_reg;
                state_next = ST_EM_PT;
            end

            ST_EM_PT:
            begin
                oval_next  = 1'b1;
                opt_next   = pt_rdata;
                olast_next = (nv_reg == start_reg) || (em_inc == cnt_reg);
                odeg_next  = 1'b0;
                state_next = ST_EM_OUT;
            end

            ST_EM_OUT:
            begin
                if (m_axis_tready)
                begin
                    oval_next = 1'b0;
                    em_next   = em_inc;
                    v_next    = nv_reg;
                    if (olast_reg)
                    begin
                        cnt_next   = '0;
                        seen_next  = '0;
                        sumx_next  = '0;
                        sumy_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EM_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            seen_reg  <= '0;
            sumx_reg  <= '0;
            sumy_reg  <= '0;
            oval_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            seen_reg  <= seen_next;
            sumx_reg  <= sumx_next;
            sumy_reg  <= sumy_next;
            oval_reg  <= oval_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        new_reg     <= new_next;
        last_reg    <= last_next;
        dup_idx_reg <= dup_idx_next;
        magx_reg    <= magx_next;
        magy_reg    <= magy_next;
        negx_reg    <= negx_next;
        negy_reg    <= negy_next;
        pivot_reg   <= pivot_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        t_reg       <= t_next;
        u_reg       <= u_next;
        before_reg  <= before_next;
        fs_reg      <= fs_next;
        best_reg    <= best_next;
        start_reg   <= start_next;
        v_reg       <= (state_reg == ST_SC_PREV) ? prv_rdata : v_next;
        nx_reg      <= nx_next;
        nn_reg      <= nn_next;
        pv_reg      <= pv_next;
        px_reg      <= px_next;
        guard_reg   <= guard_next;
        nv_reg      <= nv_next;
        em_reg      <= em_next;
        opt_reg     <= opt_next;
        olast_reg   <= olast_next;
        odeg_reg    <= odeg_next;
    end

    // Point store and the two link tables.
    chgs_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    chgs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_nxt_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (lnk_waddr),
        .wdata (nxt_wdata),
        .raddr (nxt_raddr),
        .rdata (nxt_rdata)
    );

    chgs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_prv_ram (
        .clk   (clk),
        .we    (prv_we),
        .waddr (lnk_waddr),
        .wdata (prv_wdata),
        .raddr (prv_raddr),
        .rdata (prv_rdata)
    );

    chgs_cmp u_cmp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cmp_req),
        .ax    (cax),
        .ay    (cay),
        .bx    (cbx),
        .by    (cby),
        .res   (cmp_res)
    );

    // Port drive.
    assign s_axis_tready   = (state_reg == ST_IDLE);
    assign m_axis_tvalid   = oval_reg;
    assign m_axis_tdata    = opt_reg;
    assign m_axis_tlast    = olast_reg;
    assign m_axis_tuser[0] = odeg_reg;

`ifndef SYNTHESIS
    // No point is taken while a hull vertex waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input accepted while output pending");

    // A degenerate transaction is always the final one of its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("degenerate result without last");

    // The store never holds more points than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_POINTS))
        else $error("point count overflow");

    // After the final vertex is taken the block is ready for a new run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (s_axis_tready && cnt_reg == '0))
        else $error("run state not cleared");
`endif

endmodule

`default_nettype wire
